@@ hw/rtl/trbi_pkg.sv @@
// trbi_pkg: shared types, widths, status and request codes for the record interpolator
// no dependencies; imported by every module under hw/rtl
package trbi_pkg;

  localparam int TIME_BITS   = 48;
  localparam int VALUE_BITS  = 32;
  localparam int WEIGHT_BITS = 24;

  localparam int NSLOT    = 3;
  localparam int NVAL     = 5;
  localparam int DIST_IDX = 3;   // distance is the only unsigned value

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_LOADED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;
  localparam logic [2:0] ST_NO_DATA   = 3'd5;

  typedef logic [NVAL-1:0][VALUE_BITS-1:0] trbi_vals_t;

  typedef struct packed {
    logic                          req_type;
    logic [TIME_BITS-1:0]          time_stamp;
    logic signed [VALUE_BITS-1:0]  in_x;
    logic signed [VALUE_BITS-1:0]  in_y;
    logic signed [VALUE_BITS-1:0]  in_z;
    logic [VALUE_BITS-1:0]         in_distance;
    logic signed [VALUE_BITS-1:0]  in_eqeq;
  } trbi_in_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic signed [VALUE_BITS-1:0]  out_x;
    logic signed [VALUE_BITS-1:0]  out_y;
    logic signed [VALUE_BITS-1:0]  out_z;
    logic [VALUE_BITS-1:0]         out_distance;
    logic signed [VALUE_BITS-1:0]  out_eqeq;
  } trbi_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [2:0]           status;
    logic [TIME_BITS-1:0] num;
    logic [TIME_BITS-1:0] span;
    trbi_vals_t           last_v;
    trbi_vals_t           next_v;
  } trbi_job_t;

  function automatic logic signed [VALUE_BITS:0] ext_val(input logic [VALUE_BITS-1:0] raw,
                                                         input logic is_unsigned);
    logic signed [VALUE_BITS:0] res;
    if (is_unsigned) begin
      res = $signed({1'b0, raw});
    end else begin
      res = $signed({raw[VALUE_BITS-1], raw});
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/triple_buffered_record_interpolator.sv @@
// triple_buffered_record_interpolator: top level with config register, front, queue and back
// depends on trbi_pkg, trbi_front, trbi_queue, trbi_back
//
// Holds up to three timestamped records (last, next, spare) and answers each request with
// exactly one result. A load request (req_type 0) stores its record in the first free slot,
// or returns status 2 when all three are full. A query request (req_type 1) carries a time;
// if the time lies past next and the spare is filled, the records move up by one (spare
// becomes next) and the query is answered from the new pair, otherwise it reports not ready.
// A query in range returns last + (next - last) * a for the direction vector, distance and
// equation of equinoxes, a = (t - last) / (next - last) as an unsigned fraction with 24 bits,
// or a = 0 when the span is below min_span. Requests are taken when start is high and busy
// is low; busy is high for one cycle after each request while it is classified, and longer
// when the two-entry queue ahead of the arithmetic is full. Results appear for one cycle
// with out_strobe and cannot be held off, so the receiver must take them as they come.
// Loads and failed queries pass from the front through the queue to the result register; a
// query that needs the division passes the check, the radix-2 weight divider and a blend
// pipeline shared by the five values, and skips the divider when the check finds a weight of
// 0 or 1. Results leave in request order. The user must write min_span through cfg_we /
// cfg_wdata only while no request is in flight; the block does not check. It resets to 1.
module triple_buffered_record_interpolator (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  trbi_pkg::trbi_in_t              in_req,
  // result channel
  output logic                            out_strobe,
  output trbi_pkg::trbi_out_t             out_res,
  // configuration
  input  logic                            cfg_we,
  input  logic [trbi_pkg::TIME_BITS-1:0]  cfg_wdata
);
  import trbi_pkg::*;

  logic [TIME_BITS-1:0] min_span_r;
  logic                 push;
  trbi_job_t            push_data;
  logic                 q_full;
  logic                 q_pop;
  trbi_job_t            q_data;
  logic                 q_empty;

  // span threshold; below it the last record is returned unchanged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_span_r <= TIME_BITS'(1);
    end else if (cfg_we) begin
      min_span_r <= cfg_wdata;
    end
  end

  // front: takes requests, owns the record slots, decides status and operands
  trbi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // short queue so the front keeps taking requests while a division runs
  trbi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back: weight divider, blend and result strobe
  trbi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_span   (min_span_r),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

@@ hw/rtl/trbi_front.sv @@
// trbi_front: request intake, record ring and classification of loads and queries
// depends on trbi_pkg; feeds trbi_queue
module trbi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  trbi_pkg::trbi_in_t  in_req,
  output logic                push,
  output trbi_pkg::trbi_job_t push_data,
  input  logic                q_full
);
  import trbi_pkg::*;

  logic                 front_vld_r;
  trbi_in_t             front_req_r;
  logic [1:0]           count_r;
  logic [1:0]           count_nxt;
  logic [TIME_BITS-1:0] slot_t_r [NSLOT];
  trbi_vals_t           slot_v_r [NSLOT];

  logic                 accept;
  logic                 rotate;
  logic                 wr_load;
  logic [TIME_BITS-1:0] t;
  logic                 gt_next;
  logic                 gt_spare;
  logic                 lt_last;
  trbi_vals_t           new_v;

  assign busy   = front_vld_r;
  assign accept = start && !front_vld_r;
  assign t      = front_req_r.time_stamp;

  assign gt_next  = t > slot_t_r[1];
  assign gt_spare = t > slot_t_r[2];
  assign lt_last  = t < slot_t_r[0];

  always_comb begin
    new_v[0] = front_req_r.in_x;
    new_v[1] = front_req_r.in_y;
    new_v[2] = front_req_r.in_z;
    new_v[3] = front_req_r.in_distance;
    new_v[4] = front_req_r.in_eqeq;
  end

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    count_nxt = count_r;
    rotate    = 1'b0;
    wr_load   = 1'b0;
    if (front_vld_r && !q_full) begin
      push = 1'b1;
      priority if (front_req_r.req_type == REQ_LOAD) begin
        if (count_r == 2'(NSLOT)) begin
          push_data.status = ST_FULL;
        end else begin
          push_data.status = ST_LOADED;
          wr_load          = 1'b1;
          count_nxt        = count_r + 2'd1;
        end
      end else if (count_r < 2'd2) begin
        push_data.status = ST_NO_DATA;
      end else if (gt_next) begin
        if (count_r != 2'(NSLOT)) begin
          push_data.status = ST_NOT_READY;
        end else begin
          // spare becomes next; rotation stands even if the time is out of range
          rotate    = 1'b1;
          count_nxt = 2'd2;
          if (gt_spare) begin
            push_data.status = ST_RANGE;
          end else begin
            push_data.status = ST_OK;
            push_data.num    = t - slot_t_r[1];
            push_data.span   = slot_t_r[2] - slot_t_r[1];
            push_data.last_v = slot_v_r[1];
            push_data.next_v = slot_v_r[2];
          end
        end
      end else if (lt_last) begin
        push_data.status = ST_RANGE;
      end else begin
        push_data.status = ST_OK;
        push_data.num    = t - slot_t_r[0];
        push_data.span   = slot_t_r[1] - slot_t_r[0];
        push_data.last_v = slot_v_r[0];
        push_data.next_v = slot_v_r[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
      count_r     <= 2'd0;
    end else begin
      if (accept) begin
        front_vld_r <= 1'b1;
      end else if (push) begin
        front_vld_r <= 1'b0;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_req_r <= in_req;
    end
    if (rotate) begin
      slot_t_r[0] <= slot_t_r[1];
      slot_v_r[0] <= slot_v_r[1];
      slot_t_r[1] <= slot_t_r[2];
      slot_v_r[1] <= slot_v_r[2];
    end
    if (wr_load) begin
      slot_t_r[count_r] <= t;
      slot_v_r[count_r] <= new_v;
    end
  end

endmodule

@@ hw/rtl/trbi_queue.sv @@
// trbi_queue: two-entry queue of classified requests between front and back
// depends on trbi_pkg
module trbi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  trbi_pkg::trbi_job_t push_data,
  output logic                full,
  input  logic                pop,
  output trbi_pkg::trbi_job_t pop_data,
  output logic                empty
);
  import trbi_pkg::*;

  trbi_job_t         entry_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     cnt_r;

  assign full     = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/trbi_back.sv @@
// trbi_back: weight division, per-value blend and result register
// depends on trbi_pkg; drains trbi_queue
module trbi_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [trbi_pkg::TIME_BITS-1:0] min_span,
  input  logic                  q_empty,
  input  trbi_pkg::trbi_job_t   q_data,
  output logic                  q_pop,
  output logic                  out_strobe,
  output trbi_pkg::trbi_out_t   out_res
);
  import trbi_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHK   = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_BLEND = 2'd3;

  localparam int CNT_W = $clog2(WEIGHT_BITS);
  localparam int K_W   = $clog2(NVAL + 2);
  localparam int PRD_W = VALUE_BITS + WEIGHT_BITS + 1;
  localparam int RND_W = PRD_W + 1;
  localparam logic [WEIGHT_BITS:0] A_ONE = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [RND_W-1:0]     HALF  = RND_W'(1) << (WEIGHT_BITS - 1);
  localparam logic [K_W-1:0]       K_LAST = K_W'(NVAL + 1);

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic                   out_strobe_r;
  logic                   strobe_nxt;

  logic [TIME_BITS-1:0]   num_r;
  logic [TIME_BITS-1:0]   span_r;
  trbi_vals_t             last_r;
  trbi_vals_t             next_r;
  trbi_vals_t             mag_r;
  logic [NVAL-1:0]        neg_r;
  trbi_vals_t             mag_nxt;
  logic [NVAL-1:0]        neg_nxt;
  logic [WEIGHT_BITS:0]   a_r;
  logic [TIME_BITS-1:0]   rem_r;
  logic [CNT_W-1:0]       div_cnt_r;
  logic [K_W-1:0]         k_r;
  logic [PRD_W-1:0]       prod_r;
  logic [VALUE_BITS:0]    m_r;
  logic [2:0]             status_r;
  trbi_vals_t             res_r;

  logic                   a_zero;
  logic                   a_full;
  logic [TIME_BITS:0]     rem2;
  logic [TIME_BITS:0]     den;
  logic                   div_ge;
  logic [TIME_BITS:0]     div_diff;
  logic [PRD_W-1:0]       mul;
  logic [RND_W-1:0]       rnd;
  logic [K_W-1:0]         idx2;
  logic signed [VALUE_BITS:0]   res_base;
  logic [VALUE_BITS+1:0]  res_wide;

  assign a_zero = (span_r < min_span) || (span_r == '0);
  assign a_full = num_r >= span_r;

  // restoring division, one quotient bit per cycle
  assign rem2     = {rem_r, 1'b0};
  assign den      = {1'b0, span_r};
  assign div_ge   = rem2 >= den;
  assign div_diff = rem2 - den;

  // blend pipeline: multiply, round, then add to last
  assign mul  = mag_r[k_r] * a_r;
  assign rnd  = {1'b0, prod_r} + HALF;
  assign idx2 = k_r - K_W'(2);
  assign res_base = ext_val(last_r[idx2], idx2 == K_W'(DIST_IDX));
  assign res_wide = neg_r[idx2] ? {res_base[VALUE_BITS], res_base} - {1'b0, m_r}
                                : {res_base[VALUE_BITS], res_base} + {1'b0, m_r};

  always_comb begin
    logic signed [VALUE_BITS:0]   e_l;
    logic signed [VALUE_BITS:0]   e_n;
    logic [VALUE_BITS+1:0]        d_pos;
    logic [VALUE_BITS+1:0]        d_neg;
    for (int k = 0; k < NVAL; k++) begin
      e_l   = ext_val(last_r[k], k == DIST_IDX);
      e_n   = ext_val(next_r[k], k == DIST_IDX);
      d_pos = {e_n[VALUE_BITS], e_n} - {e_l[VALUE_BITS], e_l};
      d_neg = {e_l[VALUE_BITS], e_l} - {e_n[VALUE_BITS], e_n};
      neg_nxt[k] = d_pos[VALUE_BITS+1];
      mag_nxt[k] = d_pos[VALUE_BITS+1] ? d_neg[VALUE_BITS-1:0] : d_pos[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    q_pop      = 1'b0;
    strobe_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.status == ST_OK) begin
            state_nxt = S_CHK;
          end else begin
            strobe_nxt = 1'b1;
          end
        end
      end
      S_CHK: begin
        if (a_zero || a_full) begin
          state_nxt = S_BLEND;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        if (k_r == K_LAST) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          num_r    <= q_data.num;
          span_r   <= q_data.span;
          last_r   <= q_data.last_v;
          next_r   <= q_data.next_v;
          status_r <= q_data.status;
          if (q_data.status != ST_OK) begin
            res_r <= '0;
          end
        end
      end
      S_CHK: begin
        mag_r     <= mag_nxt;
        neg_r     <= neg_nxt;
        rem_r     <= num_r;
        div_cnt_r <= CNT_W'(WEIGHT_BITS - 1);
        k_r       <= '0;
        priority if (a_zero) begin
          a_r <= '0;
        end else if (a_full) begin
          a_r <= A_ONE;
        end else begin
          a_r <= '0;
        end
      end
      S_DIV: begin
        rem_r     <= div_ge ? div_diff[TIME_BITS-1:0] : rem2[TIME_BITS-1:0];
        a_r       <= {a_r[WEIGHT_BITS-1:0], div_ge};
        div_cnt_r <= div_cnt_r - 1'b1;
      end
      S_BLEND: begin
        k_r <= k_r + 1'b1;
        if (k_r < K_W'(NVAL)) begin
          prod_r <= mul;
        end
        if (k_r >= K_W'(1) && k_r <= K_W'(NVAL)) begin
          m_r <= rnd[RND_W-2:WEIGHT_BITS];
        end
        if (k_r >= K_W'(2)) begin
          res_r[idx2] <= res_wide[VALUE_BITS-1:0];
        end
      end
    endcase
  end

  assign out_strobe           = out_strobe_r;
  assign out_res.status       = status_r;
  assign out_res.out_x        = res_r[0];
  assign out_res.out_y        = res_r[1];
  assign out_res.out_z        = res_r[2];
  assign out_res.out_distance = res_r[3];
  assign out_res.out_eqeq     = res_r[4];

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && status_r != ST_OK) |-> res_r == '0)
    else $error("failed request carries nonzero values");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == S_IDLE || $past(state_r) == S_BLEND))
    else $error("result strobe from wrong state");

  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r != '0) |=> state_r == S_DIV)
    else $error("division left early");

  a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BLEND |-> a_r <= A_ONE)
    else $error("weight above one");

endmodule

@@ tb/tb_triple_buffered_record_interpolator.sv @@
// tb_triple_buffered_record_interpolator: self-checking bench for the record interpolator
// directed table of loads, queries and min_span writes, then random phases at several min_span
// settings; depends on trbi_pkg and triple_buffered_record_interpolator
module tb_triple_buffered_record_interpolator;
  import trbi_pkg::*;

  localparam int QUIET_LIMIT = 2000;   // cycles with no request or result taken
  localparam int SETTLE      = 50;     // idle cycles before min_span writes and at the end
  localparam int PHASE_ITEMS = 310;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum {ROW_REQUEST, ROW_MIN_SPAN} row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t              kind;
    trbi_in_t               req;
    bit                     known;   // want holds a hand-written result
    trbi_out_t              want;
    logic [TIME_BITS-1:0]   span_value;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  trbi_in_t              in_req = '0;
  logic                  out_strobe;
  trbi_out_t             out_res;
  logic                  cfg_we = 1'b0;
  logic [TIME_BITS-1:0]  cfg_wdata = '0;

  // shadow copy of the ring, kept in step with accepted requests
  logic [TIME_BITS-1:0]  rec_time [NSLOT];
  trbi_vals_t            rec_val [NSLOT];
  int                    ring_head = 0;
  int                    ring_fill = 0;
  logic [TIME_BITS-1:0]  span_floor = 48'd1;

  trbi_out_t             pending_results[$];
  plan_row_t             directed_plan[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int total_requests = 0;
  int load_requests = 0;
  int rotations = 0;
  int span_writes = 0;
  int status_seen [6];

  triple_buffered_record_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < NSLOT; s++) begin
      rec_time[s] = '0;
      rec_val[s] = '0;
    end
    for (int s = 0; s < 6; s++) begin
      status_seen[s] = 0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------------------

  // unsigned fraction (t - last) / span with WEIGHT_BITS fraction bits, restoring division
  function automatic logic [WEIGHT_BITS:0] span_fraction(input logic [TIME_BITS-1:0] num,
                                                         input logic [TIME_BITS-1:0] den);
    logic [TIME_BITS:0]    rem;
    logic [WEIGHT_BITS:0]  q;
    if (num >= den) begin
      return {1'b1, {WEIGHT_BITS{1'b0}}};
    end
    rem = {1'b0, num};
    q = '0;
    for (int i = 0; i < WEIGHT_BITS; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // last + sgn(d) * round(|d| * a), half away from zero, d = next - last
  function automatic logic [VALUE_BITS-1:0] blend_value(input logic [VALUE_BITS-1:0] lst_raw,
                                                        input logic [VALUE_BITS-1:0] nxt_raw,
                                                        input bit is_unsigned,
                                                        input logic [WEIGHT_BITS:0] a);
    logic [63:0] lst;
    logic [63:0] nxt;
    logic [63:0] d;
    logic [63:0] mag;
    logic [63:0] res;
    lst = is_unsigned ? {32'b0, lst_raw} : {{32{lst_raw[VALUE_BITS-1]}}, lst_raw};
    nxt = is_unsigned ? {32'b0, nxt_raw} : {{32{nxt_raw[VALUE_BITS-1]}}, nxt_raw};
    d = nxt - lst;
    mag = d[63] ? -d : d;
    mag = (mag * {39'b0, a} + (64'd1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;
    res = d[63] ? lst - mag : lst + mag;
    return res[VALUE_BITS-1:0];
  endfunction

  // updates the shadow ring for one accepted request and returns the result it should give
  function automatic trbi_out_t apply_request(input trbi_in_t r);
    trbi_out_t             res;
    logic [TIME_BITS-1:0]  t;
    logic [TIME_BITS-1:0]  span;
    logic [WEIGHT_BITS:0]  a;
    trbi_vals_t            mixed;
    int                    slot;
    int                    lst_slot;
    int                    nxt_slot;
    res = '0;
    t = r.time_stamp;
    if (r.req_type == REQ_LOAD) begin
      if (ring_fill == NSLOT) begin
        res.status = ST_FULL;
      end else begin
        slot = (ring_head + ring_fill) % NSLOT;
        rec_time[slot] = t;
        rec_val[slot] = {r.in_eqeq, r.in_distance, r.in_z, r.in_y, r.in_x};
        ring_fill++;
        res.status = ST_LOADED;
      end
      return res;
    end
    if (ring_fill < 2) begin
      res.status = ST_NO_DATA;
      return res;
    end
    // past next: move up one record if the spare is there
    if (t > rec_time[(ring_head + 1) % NSLOT]) begin
      if (ring_fill < NSLOT) begin
        res.status = ST_NOT_READY;
        return res;
      end
      ring_head = (ring_head + 1) % NSLOT;
      ring_fill = 2;
      rotations++;
    end
    lst_slot = ring_head;
    nxt_slot = (ring_head + 1) % NSLOT;
    if (t < rec_time[lst_slot] || t > rec_time[nxt_slot]) begin
      res.status = ST_RANGE;
      return res;
    end
    span = rec_time[nxt_slot] - rec_time[lst_slot];
    if (span < span_floor || span == '0) begin
      a = '0;
    end else begin
      a = span_fraction(t - rec_time[lst_slot], span);
    end
    for (int k = 0; k < NVAL; k++) begin
      mixed[k] = blend_value(rec_val[lst_slot][k], rec_val[nxt_slot][k], k == DIST_IDX, a);
    end
    res.status = ST_OK;
    res.out_x = mixed[0];
    res.out_y = mixed[1];
    res.out_z = mixed[2];
    res.out_distance = mixed[3];
    res.out_eqeq = mixed[4];
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // table and stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic trbi_out_t status_only(input logic [2:0] st);
    trbi_out_t o;
    o = '0;
    o.status = st;
    return o;
  endfunction

  function automatic trbi_out_t ok_result(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [31:0] distance,
                                          input logic [31:0] eqeq);
    trbi_out_t o;
    o.status = ST_OK;
    o.out_x = x;
    o.out_y = y;
    o.out_z = z;
    o.out_distance = distance;
    o.out_eqeq = eqeq;
    return o;
  endfunction

  // load row; its status is always known by hand (loaded or refused)
  function automatic plan_row_t ld(input logic [TIME_BITS-1:0] t, input logic [31:0] x,
                                   input logic [31:0] y, input logic [31:0] z,
                                   input logic [31:0] distance, input logic [31:0] eqeq,
                                   input logic [2:0] st);
    plan_row_t row;
    row.kind = ROW_REQUEST;
    row.req.req_type = REQ_LOAD;
    row.req.time_stamp = t;
    row.req.in_x = x;
    row.req.in_y = y;
    row.req.in_z = z;
    row.req.in_distance = distance;
    row.req.in_eqeq = eqeq;
    row.known = 1'b1;
    row.want = status_only(st);
    row.span_value = '0;
    return row;
  endfunction

  function automatic plan_row_t qry(input logic [TIME_BITS-1:0] t, input bit known,
                                    input trbi_out_t want);
    plan_row_t row;
    row.kind = ROW_REQUEST;
    row.req = '0;
    row.req.req_type = REQ_QUERY;
    row.req.time_stamp = t;
    row.known = known;
    row.want = want;
    row.span_value = '0;
    return row;
  endfunction

  function automatic plan_row_t set_span(input logic [TIME_BITS-1:0] v);
    plan_row_t row;
    row.kind = ROW_MIN_SPAN;
    row.req = '0;
    row.known = 1'b0;
    row.want = '0;
    row.span_value = v;
    return row;
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_BITS-1:0];
  endfunction

  // random time in [lo, hi], anywhere when the pair is out of order
  function automatic logic [TIME_BITS-1:0] pick_between(input logic [TIME_BITS-1:0] lo,
                                                        input logic [TIME_BITS-1:0] hi);
    logic [63:0] width;
    logic [63:0] w;
    if (hi < lo) begin
      return rand_time();
    end
    width = {16'b0, hi} - {16'b0, lo} + 64'd1;
    w = {$urandom, $urandom} % width;
    return lo + w[TIME_BITS-1:0];
  endfunction

  // mostly random values, now and then a corner value
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------------------

  // present one request and hold it until busy is low at an edge
  task automatic send_request(input trbi_in_t r, input bit known, input trbi_out_t want);
    trbi_out_t predicted;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_request(r);
    pending_results.push_back(known ? want : predicted);
    total_requests++;
    if (r.req_type == REQ_LOAD) begin
      load_requests++;
    end
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // min_span only changes with nothing in flight
  task automatic set_min_span(input logic [TIME_BITS-1:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    span_floor = v;
    span_writes++;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // result checking and watchdog
  // ---------------------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    trbi_out_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %h", $time,
                 out_res);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", {29'b0, want.status}, {29'b0, out_res.status});
        compare_field("out_x", want.out_x, out_res.out_x);
        compare_field("out_y", want.out_y, out_res.out_y);
        compare_field("out_z", want.out_z, out_res.out_z);
        compare_field("out_distance", want.out_distance, out_res.out_distance);
        compare_field("out_eqeq", want.out_eqeq, out_res.out_eqeq);
      end
      if (out_res.status < 6) begin
        status_seen[out_res.status]++;
      end
    end
  end

  // run ends if neither a request nor a result is taken for too long
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
               QUIET_LIMIT, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    int                    choice;
    bit                    gappy;
    logic [TIME_BITS-1:0]  lo;
    logic [TIME_BITS-1:0]  hi;
    logic [TIME_BITS-1:0]  spare_t;
    logic [TIME_BITS-1:0]  advance;
    logic [TIME_BITS-1:0]  track_time;
    logic [TIME_BITS-1:0]  span_v;
    trbi_in_t              item;

    // directed table: corner values, every status, ring rotation, span corner cases
    directed_plan.push_back(qry(48'd0, 1'b1, status_only(ST_NO_DATA)));   // empty ring
    directed_plan.push_back(ld(48'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                               32'hFFFF_FFFF, ST_LOADED));
    directed_plan.push_back(qry(48'd100, 1'b1, status_only(ST_NO_DATA)));  // one record only
    directed_plan.push_back(ld(48'd1100, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 32'h0, ST_LOADED));
    // t at last gives last, t at next gives next, full-scale swings
    directed_plan.push_back(qry(48'd100, 1'b1, ok_result(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                                        32'h0, 32'hFFFF_FFFF)));
    directed_plan.push_back(qry(48'd1100, 1'b1, ok_result(32'h8000_0000, 32'h7FFF_FFFF,
                                                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0)));
    directed_plan.push_back(qry(48'd600, 1'b0, '0));                        // midpoint
    directed_plan.push_back(qry(48'd99, 1'b1, status_only(ST_RANGE)));     // before last
    directed_plan.push_back(qry(48'd1101, 1'b1, status_only(ST_NOT_READY)));  // no spare
    directed_plan.push_back(ld(48'd2100, 32'h1234_5678, 32'hEDCB_A988, 32'h4000_0000,
                               32'h0100_0000, 32'hC000_0000, ST_LOADED));
    directed_plan.push_back(ld(48'd2200, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, ST_FULL));
    directed_plan.push_back(qry(48'd1700, 1'b0, '0));                       // rotates
    directed_plan.push_back(ld(48'd3100, 32'h0, 32'h3FFF_FFFF, 32'hC000_0001, 32'h7F00_0000,
                               32'h0000_0001, ST_LOADED));
    directed_plan.push_back(qry(48'd5000, 1'b1, status_only(ST_RANGE)));   // rotate, then range
    directed_plan.push_back(qry(48'd3100, 1'b0, '0));
    directed_plan.push_back(set_span(48'd0));
    directed_plan.push_back(ld(48'd3100, 32'hABCD_EF01, 32'h1020_3040, 32'hF0E0_D0C0,
                               32'h00FF_00FF, 32'h7FFF_FFFF, ST_LOADED));
    directed_plan.push_back(qry(48'd3100, 1'b0, '0));
    directed_plan.push_back(qry(48'd3101, 1'b1, status_only(ST_RANGE)));   // leaves zero span
    directed_plan.push_back(qry(48'd3100, 1'b0, '0));                       // zero span pair
    directed_plan.push_back(set_span(TIME_MAX));
    directed_plan.push_back(ld(48'd4000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'hFFFF_FFFF, 32'h8000_0000, ST_LOADED));
    directed_plan.push_back(qry(48'd3500, 1'b0, '0));                       // span under floor
    directed_plan.push_back(ld(48'd10, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                               32'hF0F0_F0F0, 32'h3333_3333, ST_LOADED));  // out of order
    directed_plan.push_back(qry(TIME_MAX, 1'b1, status_only(ST_RANGE)));
    directed_plan.push_back(ld(48'd0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0,
                               32'h7FFF_FFFF, ST_LOADED));
    directed_plan.push_back(qry(48'd5, 1'b1, status_only(ST_RANGE)));

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_MIN_SPAN) begin
        set_min_span(directed_plan[i].span_value);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          hold_off($urandom_range(1, 7));
        end
        send_request(directed_plan[i].req, directed_plan[i].known, directed_plan[i].want);
      end
    end

    // random phases, each at its own min_span; the last one runs without gaps
    track_time = '0;
    gappy = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: span_v = '0;
        1: span_v = TIME_MAX;
        2, 3: span_v = TIME_BITS'($urandom_range(0, 4096));
        default: span_v = 48'd1;
      endcase
      set_min_span(span_v);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate gappy and calm stretches
        if (n % 40 == 0) begin
          gappy = (ph != 4) && ($urandom_range(0, 2) != 0);
        end
        if (gappy && $urandom_range(0, 3) == 0) begin
          hold_off($urandom_range(1, 7));
        end

        item.req_type = REQ_QUERY;
        item.in_x = pick_value();
        item.in_y = pick_value();
        item.in_z = pick_value();
        item.in_distance = pick_value();
        item.in_eqeq = pick_value();
        lo = rec_time[ring_head];
        hi = rec_time[(ring_head + 1) % NSLOT];
        spare_t = rec_time[(ring_head + 2) % NSLOT];
        choice = $urandom_range(0, 99);

        // mostly a forward-moving track of records with queries between them
        if (ring_fill < 2 || (ring_fill == 2 && choice < 50)) begin
          item.req_type = REQ_LOAD;
          case ($urandom_range(0, 15))
            0: advance = '0;
            1: advance = {16'b0, $urandom};
            2: advance = 48'd1;
            default: advance = TIME_BITS'($urandom_range(1, 4096));
          endcase
          track_time = track_time + advance;
          item.time_stamp = ($urandom_range(0, 19) == 0) ? rand_time() : track_time;
        end else if (ring_fill == 2) begin
          if (choice < 85) begin
            item.time_stamp = pick_between(lo, hi);
          end else if (choice < 93) begin
            item.time_stamp = pick_between(hi + 48'd1, hi + 48'd4096);
          end else begin
            item.time_stamp = rand_time();
          end
        end else begin
          if (choice < 45) begin
            item.time_stamp = pick_between(hi + 48'd1, spare_t);
          end else if (choice < 80) begin
            item.time_stamp = pick_between(lo, hi);
          end else if (choice < 90) begin
            item.req_type = REQ_LOAD;   // refused, ring full
            item.time_stamp = rand_time();
          end else begin
            item.time_stamp = rand_time();
          end
        end
        send_request(item, 1'b0, '0);
      end
    end

    // drain, then watch for stray results
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests (%0d loads), %0d ring rotations, %0d min_span writes",
             total_requests, load_requests, rotations, span_writes);
    $display("status mix ok/loaded/full/not-ready/range/no-data: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
